// ===== rtl/core/lurt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurt_pkg
// Shared types and constants for the longest unique run tracker.
// ----------------------------------------------------------------------------
package lurt_pkg;

  localparam int SYMBOLS  = 256;
  localparam int POS_BITS = 32;
  localparam int SYM_BITS = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int LEN_BITS = 9;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [SYM_BITS-1:0] sym_t;
  typedef logic [LEN_BITS-1:0] len_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first;
  } in_item_t;

  typedef struct packed {
    len_t run_len;
    len_t best_len;
    logic count_overflow;
  } out_item_t;

  // Table write request from the window stage
  typedef struct packed {
    logic en;
    sym_t sym;
    pos_t pos;
  } tbl_wr_t;

  // Byte to table index: byte modulo SYMBOLS, restoring remainder by a constant
  function automatic sym_t sym_of(input logic [7:0] b);
    logic [SYM_BITS+1:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[SYM_BITS:0], b[i]};
      if (r >= (SYM_BITS+2)'(SYMBOLS)) begin
        r = r - (SYM_BITS+2)'(SYMBOLS);
      end
    end
    return r[SYM_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lurt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lurt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                                        clk_i,
  input  wire                                        we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                            wdata_i,
  input  wire                                        re_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lurt_last_pos.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurt_last_pos
// Last-seen position table: RAM, per-entry valid bits and write bypass.
// ----------------------------------------------------------------------------
module lurt_last_pos
  import lurt_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     rd_en_i,
  input  sym_t    rd_sym_i,
  input  tbl_wr_t wr_i,
  output pos_t    prev_o
);

  logic [SYMBOLS-1:0] valid_q;
  logic               vld_q;
  logic               byp_q;
  pos_t               byp_pos_q;
  pos_t               rd_data;

  lurt_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (SYMBOLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.sym),
    .wdata_i (wr_i.pos),
    .re_i    (rd_en_i),
    .raddr_i (rd_sym_i),
    .rdata_o (rd_data)
  );

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.sym] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_q <= valid_q[rd_sym_i];
        byp_q <= wr_i.en && (wr_i.sym == rd_sym_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_pos_q <= wr_i.pos;
    end
  end

  assign prev_o = byp_q ? byp_pos_q : (vld_q ? rd_data : '0);

endmodule

`default_nettype wire

// ===== rtl/core/lurt_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurt_window
// Window start, position counter, best length and overflow update.
// ----------------------------------------------------------------------------
module lurt_window
  import lurt_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       fire_i,
  input  wire       first_i,
  input  pos_t      prev_i,
  output pos_t      pos_o,
  output out_item_t result_o
);

  pos_t pos_q, pos_d;
  pos_t ws_q, ws_d;
  len_t best_q, best_d;
  logic ovf_q, ovf_d;

  pos_t ws_base;
  pos_t diff;
  len_t best_base;
  len_t run;
  logic at_max;
  logic hit;

  always_comb begin
    at_max  = (pos_q == POS_MAX);
    ovf_d   = ovf_q | at_max;
    ws_base = first_i ? pos_q : ws_q;
    hit     = (prev_i != '0) && (prev_i >= ws_base);
    if (hit) begin
      ws_d = (prev_i == POS_MAX) ? POS_MAX : prev_i + POS_ONE;
    end else begin
      ws_d = ws_base;
    end

    diff = pos_q - ws_d;
    if (ws_d > pos_q) begin
      run = LEN_BITS'(1);
    end else if (diff >= POS_BITS'(LEN_MAX - LEN_BITS'(1))) begin
      run = LEN_MAX;
    end else begin
      run = diff[LEN_BITS-1:0] + LEN_BITS'(1);
    end

    best_base = first_i ? '0 : best_q;
    best_d    = (run > best_base) ? run : best_base;
    pos_d     = at_max ? pos_q : pos_q + POS_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_ONE;
      ws_q   <= POS_ONE;
      best_q <= '0;
      ovf_q  <= 1'b0;
    end else if (fire_i) begin
      pos_q  <= pos_d;
      ws_q   <= ws_d;
      best_q <= best_d;
      ovf_q  <= ovf_d;
    end
  end

  assign pos_o                   = pos_q;
  assign result_o.run_len        = run;
  assign result_o.best_len       = best_d;
  assign result_o.count_overflow = ovf_d;

endmodule

`default_nettype wire

// ===== rtl/core/longest_unique_run_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_unique_run_tracker
// Streaming longest repeat-free run tracker, one byte per request.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result: the length of the repeat-free
// window ending at that byte, the longest such window since the last byte
// flagged first, and a sticky overflow flag set once the 32-bit position
// counter saturates. The block sustains one byte per clock while the output
// is not stalled. The table read of the byte's last-seen position is issued
// in the accepting cycle; the window stage then updates the window and writes
// the table back, and the result lands in the output register. A bypass
// register covers a byte that repeats the previous one. The block holds at
// most two requests (window stage plus output register); with both full and
// the output stalled, in_ready_o drops. Table entries are cleared by reset
// through per-entry valid bits, so the block is ready right after reset with
// no clearing pass.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker
  import lurt_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_item_o
);

  // stage 1: table data arrives, window update happens here
  logic      s1_valid_q;
  logic      s1_first_q;
  sym_t      s1_sym_q;
  logic      s1_fire;
  logic      in_fire;

  logic      out_valid_q;
  out_item_t out_item_q;

  pos_t      prev;
  pos_t      cur_pos;
  out_item_t result;
  tbl_wr_t   tbl_wr;
  sym_t      in_sym;

  // stage 1 advances whenever the output register is free or being drained
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_sym     = sym_of(in_item_i.byte_value);

  assign tbl_wr.en  = s1_fire;
  assign tbl_wr.sym = s1_sym_q;
  assign tbl_wr.pos = cur_pos;

  lurt_last_pos u_last_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_sym_i (in_sym),
    .wr_i     (tbl_wr),
    .prev_o   (prev)
  );

  lurt_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .first_i  (s1_first_q),
    .prev_i   (prev),
    .pos_o    (cur_pos),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q <= in_item_i.first;
      s1_sym_q   <= in_sym;
    end
    if (s1_fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/lurt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurt_checker
// Port-level checks for the longest unique run tracker.
// ----------------------------------------------------------------------------
module lurt_checker
  import lurt_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input in_item_t  in_item_i,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input out_item_t out_item_o
);

  logic ovf_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && out_item_o.count_overflow) begin
      ovf_seen_q <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // window never exceeds best and is never empty
  a_len_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.run_len != '0) &&
                    (out_item_o.run_len <= out_item_o.best_len))
    else $error("run_len out of order with best_len");

  // overflow is sticky across results
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ovf_seen_q |-> out_item_o.count_overflow)
    else $error("overflow flag dropped");

  // empty output register never blocks input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind longest_unique_run_tracker lurt_checker u_lurt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== tb/sv/tb_longest_unique_run_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_unique_run_tracker
// Self-checking bench: byte strings in, run and best lengths checked per byte.
// ----------------------------------------------------------------------------
// A behavioral copy of the tracker (last-seen table, position counter, window
// start, best length, sticky overflow) is updated on every accepted request
// and queues the result it expects. The result checker pops that queue on
// every accepted result and compares field by field. Stimulus runs through
// named tests: directed corner bytes, full 256-symbol strings, random strings
// over small and large alphabets, a long receiver hold-off, a drain pause, a
// stretch without idling and random noise with random first flags.
// ----------------------------------------------------------------------------
module tb_longest_unique_run_tracker;
  import lurt_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  longest_unique_run_tracker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // Idling controls, shared by sender and receiver
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int hold_left = 0;     // receiver hold-off, counted down by the receiver

  int        mismatches = 0;
  out_item_t expected_runs[$];

  // --------------------------------------------------------------------------
  // Tracker state as the bench sees it
  // --------------------------------------------------------------------------
  pos_t        seen_at[SYMBOLS];  // 0 = symbol never seen
  pos_t        next_pos;
  pos_t        span_start;
  int unsigned best_span;
  logic        sat_seen;

  function automatic void clear_tracker();
    foreach (seen_at[i]) seen_at[i] = '0;
    next_pos   = POS_ONE;
    span_start = POS_ONE;
    best_span  = 0;
    sat_seen   = 1'b0;
  endfunction

  // Advances the tracker by one byte and returns the result it should produce
  function automatic out_item_t predict_run(input in_item_t req);
    int unsigned        idx;
    int unsigned        run;
    pos_t               here;
    pos_t               prev;
    pos_t               diff;
    out_item_t          res;
    idx  = int'(req.byte_value) % SYMBOLS;
    here = next_pos;
    if (here == POS_MAX) sat_seen = 1'b1;
    // first flag: window and best restart at this byte
    if (req.first) begin
      span_start = here;
      best_span  = 0;
    end
    // earlier copy inside the window pushes the window start past it
    prev = seen_at[idx];
    if (prev != '0 && prev >= span_start) begin
      span_start = (prev == POS_MAX) ? POS_MAX : prev + POS_ONE;
    end
    seen_at[idx] = here;
    if (span_start > here) begin
      run = 1;
    end else begin
      diff = here - span_start;
      run  = (diff >= int'(LEN_MAX) - 1) ? int'(LEN_MAX) : int'(diff) + 1;
    end
    if (run > best_span) best_span = run;
    if (here != POS_MAX) next_pos = here + POS_ONE;
    res.run_len        = len_t'(run);
    res.best_len       = len_t'(best_span);
    res.count_overflow = sat_seen;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when a test asks for one
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stalls_on) begin
        out_ready <= ($urandom_range(99) >= 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Requests are predicted before results are popped, so the
  // order inside one edge never matters.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_runs = {expected_runs, predict_run(in_item)};
      end
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result run=%0d best=%0d ovf=%0b", $realtime,
                     out_item.run_len, out_item.best_len, out_item.count_overflow);
          end
        end else begin
          want = expected_runs.pop_front();
          if (out_item.run_len !== want.run_len || out_item.best_len !== want.best_len ||
              out_item.count_overflow !== want.count_overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: exp run=%0d best=%0d ovf=%0b, got run=%0d best=%0d ovf=%0b",
                       $realtime, want.run_len, want.best_len, want.count_overflow,
                       out_item.run_len, out_item.best_len, out_item.count_overflow);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one request, with optional random idle cycles in front of it.
  // Called right after a rising edge; returns at the edge that accepts it.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic f);
    in_item_t req;
    req.byte_value = b;
    req.first      = f;
    while (gaps_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender goes quiet until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Bytes before any first flag form one string from position 1; covers
  // byte extremes, back-to-back repeats and repeats two apart.
  task automatic test_corner_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);   // repeat two apart
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);   // back-to-back repeat
    send_byte(8'h42, 1'b0);
    // first flag on a fresh string, then first on the same byte again
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h80, 1'b0);   // copy inside window moves the start
    send_byte(8'h01, 1'b0);   // copy right at the new start
    send_byte(8'hFF, 1'b0);   // copy before the window start is ignored
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    // new string whose bytes all appeared in the last one
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
  endtask

  // All 256 symbols once in shuffled order: run and best reach 256,
  // then a repeat cuts the window.
  task automatic test_full_alphabet(input int n_strings);
    logic [7:0] perm[256];
    logic [7:0] tmp;
    int         j;
    for (int s = 0; s < n_strings; s++) begin
      foreach (perm[i]) perm[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
        j       = $urandom_range(i, 0);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      for (int i = 0; i < 256; i++) send_byte(perm[i], i == 0);
      send_byte(perm[$urandom_range(255, 0)], 1'b0);
    end
  endtask

  // Well-formed strings over alphabets of varying size, mostly short
  task automatic test_random_strings(input int n_strings);
    int         alpha;
    int         len;
    logic [7:0] base;
    for (int s = 0; s < n_strings; s++) begin
      case ($urandom_range(3))
        0:       alpha = 2;
        1:       alpha = 6;
        2:       alpha = 26;
        default: alpha = 256;
      endcase
      len  = ($urandom_range(15) == 0) ? $urandom_range(300, 60) : $urandom_range(30, 1);
      base = 8'($urandom);
      for (int k = 0; k < len; k++) begin
        send_byte(base + 8'($urandom_range(alpha - 1)), k == 0);
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing,
  // so the pipeline fills and the input stalls.
  task automatic test_output_holdoff();
    gaps_on   = 1'b0;
    hold_left = 300;
    test_random_strings(3);
    for (int k = 0; k < 40; k++) send_byte(8'h30 + 8'($urandom_range(9)), k == 0);
    gaps_on = 1'b1;
  endtask

  // Sender pauses until the block has delivered everything
  task automatic test_drain_pause();
    test_random_strings(2);
    drain_results();
    test_random_strings(2);
  endtask

  // Both sides at full rate
  task automatic test_full_rate();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_strings(8);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Unstructured bytes, first flag about one time in ten
  task automatic test_noise(input int n_items);
    for (int k = 0; k < n_items; k++) begin
      send_byte(8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    clear_tracker();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_bytes();
    test_full_alphabet(2);
    test_random_strings(20);
    test_drain_pause();
    test_output_holdoff();
    test_full_rate();
    test_noise(150);

    drain_results();
    repeat (10) @(posedge clk);
    mismatches += expected_runs.size();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lurt_pkg.sv
rtl/core/lurt_ram.sv
rtl/core/lurt_last_pos.sv
rtl/core/lurt_window.sv
rtl/core/longest_unique_run_tracker.sv
rtl/core/lurt_checker.sv
tb/sv/tb_longest_unique_run_tracker.sv
